/* rtl/bis_pkg.sv */
// Shared constants, codes and types of the bilinear image sampler.
// Used by the channel interfaces and every sampler module.
package bis_pkg;

   localparam int STORE_DEPTH = 262144;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int FRAC_BITS   = 8;
   localparam int MAX_DIM     = 4096;

   localparam int POS_W       = 20;
   localparam int INT_W       = POS_W - FRAC_BITS;
   localparam int DIM_W       = 13;
   localparam int CHAN_W      = 3;
   localparam int SEL_W       = 2;
   localparam int DATA_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = DIM_W;

   localparam int WEIGHT_BITS = 16;
   localparam int WEIGHT_W    = WEIGHT_BITS + 1;
   localparam int WEIGHT_ONE  = 1 << WEIGHT_BITS;
   localparam int STRIDE_W    = DIM_W + CHAN_W - 1;
   localparam int ROWOFF_W    = INT_W + STRIDE_W;
   localparam int COLOFF_W    = INT_W + CHAN_W;
   localparam int BASE_W      = ROWOFF_W + 1;
   localparam int ACC_W       = WEIGHT_W + DATA_W;
   localparam int VALUE_W     = 16;
   localparam int OUT_SHIFT   = WEIGHT_BITS - 8;

   localparam int NBR_COUNT   = 4;
   localparam int NBR_W       = $clog2(NBR_COUNT);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int CHANS_RESET  = 3;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH    = 2'd0,
      CSR_HEIGHT   = 2'd1,
      CSR_CHANNELS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_DRAIN,
      BK_PUSH
   } back_state_type;

   typedef struct packed {
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [CHAN_W-1:0]   chans;
      logic [STRIDE_W-1:0] stride;
   } cfg_type;

   typedef struct packed {
      logic                mode;
      logic [STORE_AW-1:0] write_addr;
      logic [DATA_W-1:0]   write_data;
      logic [POS_W-1:0]    x_pos;
      logic [POS_W-1:0]    y_pos;
      logic [SEL_W-1:0]    channel;
   } req_type;

   typedef struct packed {
      logic                 mode;
      logic [STORE_AW-1:0]  waddr;
      logic [DATA_W-1:0]    wdata;
      logic                 in_range;
      logic [ROWOFF_W-1:0]  row_off;
      logic [COLOFF_W-1:0]  col_off;
      logic [SEL_W-1:0]     ch;
      logic [FRAC_BITS-1:0] fx;
      logic [FRAC_BITS-1:0] fy;
   } fstage_type;

   typedef struct packed {
      logic                   is_write;
      logic                   in_range;
      logic [STORE_AW-1:0]    waddr;
      logic [DATA_W-1:0]      wdata;
      logic [BASE_W-1:0]      base;
      logic [FRAC_BITS-1:0]   fx;
      logic [FRAC_BITS-1:0]   fy;
      logic [WEIGHT_BITS-1:0] a3;
   } cmd_type;

endpackage

/* rtl/bis_if.sv */
// Valid/ready channel interfaces of the sampler: request and response.
// Depends on bis_pkg for field widths.
interface bis_req_if import bis_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                mode;
   logic [STORE_AW-1:0] write_addr;
   logic [DATA_W-1:0]   write_data;
   logic [POS_W-1:0]    x_pos;
   logic [POS_W-1:0]    y_pos;
   logic [SEL_W-1:0]    channel;

   modport source (output valid, mode, write_addr, write_data, x_pos, y_pos, channel,
                   input ready);
   modport sink   (input valid, mode, write_addr, write_data, x_pos, y_pos, channel,
                   output ready);
endinterface

interface bis_rsp_if import bis_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] sample_value;
   logic               in_range;

   modport source (output valid, sample_value, in_range, input ready);
   modport sink   (input valid, sample_value, in_range, output ready);
endinterface

/* rtl/bilinear_image_sampler_unit.sv */
// Bilinear image sampler top level: register file, front end, command queue, back end.
// Write: stored by the back end straight from idle; a write transfer is taken every cycle while the queue has room.
// Sample: the back end takes no new command until it has loaded the weights, read the four
// neighbors from the single-port frame memory in turn, drained and pushed the response.
// Out-of-range sample: zero response from idle. Synchronous active-high reset clears control
// state and loads 640 x 480 x 3; frame memory contents are undefined until written.
module bilinear_image_sampler_unit import bis_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bis_req_if.sink               req_if,
   bis_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [DIM_W-1:0]    width_ff, width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [CHAN_W-1:0]   chans_ff, chans_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [DIM_W-1:0]    dim_sat;
   cfg_type             cfg;

   cmd_type push_cmd, pop_cmd;
   logic    push_valid, push_ready, pop_valid, pop_ready;

   assign dim_sat = (csr_wdata > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : csr_wdata;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      chans_in  = chans_ff;
      stride_in = STRIDE_W'(width_ff) * STRIDE_W'(chans_ff);
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:    width_in  = dim_sat;
            CSR_HEIGHT:   height_in = dim_sat;
            CSR_CHANNELS: chans_in  = csr_wdata[CHAN_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(WIDTH_RESET);
         height_ff <= DIM_W'(HEIGHT_RESET);
         chans_ff  <= CHAN_W'(CHANS_RESET);
         stride_ff <= STRIDE_W'(WIDTH_RESET * CHANS_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         chans_ff  <= chans_in;
         stride_ff <= stride_in;
      end
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;
   assign cfg.chans  = chans_ff;
   assign cfg.stride = stride_ff;

   bis_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   bis_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_cmd    (pop_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   bis_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_cmd   (pop_cmd),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

   assert property (@(posedge clock) disable iff (reset)
      (width_ff <= DIM_W'(MAX_DIM)) && (height_ff <= DIM_W'(MAX_DIM)))
      else $error("image dimension above limit");

   assert property (@(posedge clock) disable iff (reset)
      !$past(csr_we) |-> (stride_ff == STRIDE_W'(width_ff) * STRIDE_W'(chans_ff)))
      else $error("row stride out of step with width and channels");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.in_range) |-> (rsp_if.sample_value == '0))
      else $error("out-of-range response carries a nonzero value");

endmodule

/* rtl/bis_front.sv */
// Front end: takes request transfers, checks range, forms base offsets and the fx*fy weight product.
// Depends on bis_pkg and bis_req_if; feeds the command queue.
module bis_front import bis_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bis_req_if.sink     req_if,
   input  cfg_type     cfg,
   output cmd_type     push_cmd,
   output logic        push_valid,
   input  logic        push_ready
);

   logic       s1_valid_ff, s1_valid_in;
   req_type    s1_ff, s1_in;
   logic       s2_valid_ff, s2_valid_in;
   fstage_type s2_ff, s2_in;

   logic                req_fire;
   logic                s2_adv;
   logic [INT_W-1:0]    ix, iy;
   logic                range_ok;
   logic [ROWOFF_W-1:0] row_off;
   logic [COLOFF_W-1:0] col_off;

   assign s2_adv       = !s2_valid_ff || push_ready;
   assign req_if.ready = !s1_valid_ff || s2_adv;
   assign req_fire     = req_if.valid && req_if.ready;

   assign ix = s1_ff.x_pos[POS_W-1:FRAC_BITS];
   assign iy = s1_ff.y_pos[POS_W-1:FRAC_BITS];

   assign range_ok = (CHAN_W'(s1_ff.channel) < cfg.chans)
                  && (cfg.width >= DIM_W'(2)) && (cfg.height >= DIM_W'(2))
                  && (DIM_W'(ix) < cfg.width - DIM_W'(1))
                  && (DIM_W'(iy) < cfg.height - DIM_W'(1));

   assign row_off = ROWOFF_W'(iy) * ROWOFF_W'(cfg.stride);
   assign col_off = COLOFF_W'(ix) * COLOFF_W'(cfg.chans);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (req_fire) begin
         s1_valid_in      = 1'b1;
         s1_in.mode       = req_if.mode;
         s1_in.write_addr = req_if.write_addr;
         s1_in.write_data = req_if.write_data;
         s1_in.x_pos      = req_if.x_pos;
         s1_in.y_pos      = req_if.y_pos;
         s1_in.channel    = req_if.channel;
      end else if (s2_adv) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      s2_in       = s2_ff;
      if (s2_adv) begin
         s2_valid_in    = s1_valid_ff;
         s2_in.mode     = s1_ff.mode;
         s2_in.waddr    = s1_ff.write_addr;
         s2_in.wdata    = s1_ff.write_data;
         s2_in.in_range = range_ok;
         s2_in.row_off  = row_off;
         s2_in.col_off  = col_off;
         s2_in.ch       = s1_ff.channel;
         s2_in.fx       = s1_ff.x_pos[FRAC_BITS-1:0];
         s2_in.fy       = s1_ff.y_pos[FRAC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   always_comb begin
      push_valid        = s2_valid_ff;
      push_cmd.is_write = (s2_ff.mode == MODE_WRITE);
      push_cmd.in_range = s2_ff.in_range;
      push_cmd.waddr    = s2_ff.waddr;
      push_cmd.wdata    = s2_ff.wdata;
      push_cmd.base     = BASE_W'(s2_ff.row_off) + BASE_W'(s2_ff.col_off)
                        + BASE_W'(s2_ff.ch);
      push_cmd.fx       = s2_ff.fx;
      push_cmd.fy       = s2_ff.fy;
      push_cmd.a3       = WEIGHT_BITS'(s2_ff.fx) * WEIGHT_BITS'(s2_ff.fy);
   end

endmodule

/* rtl/bis_queue.sv */
// Short command queue between the sampler front end and back end.
// Depends on bis_pkg for the command type and depth.
module bis_queue import bis_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type push_cmd,
   input  logic    push_valid,
   output logic    push_ready,
   output cmd_type pop_cmd,
   output logic    pop_valid,
   input  logic    pop_ready
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push_fire, pop_fire;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/bis_back.sv */
// Back end: frame memory, four-neighbor fetch sequencer, blend and response register.
// Depends on bis_pkg and bis_rsp_if; drains the command queue.
module bis_back import bis_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  cmd_type    pop_cmd,
   input  logic       pop_valid,
   output logic       pop_ready,
   bis_rsp_if.source  rsp_if
);

   logic [DATA_W-1:0] mem [STORE_DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   back_state_type     state_ff, state_in;
   logic [NBR_W-1:0]   nbr_ff, nbr_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic [WEIGHT_W-1:0] w_ff [NBR_COUNT];
   logic [WEIGHT_W-1:0] w_in [NBR_COUNT];
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [NBR_W-1:0]   rd_sel_ff, rd_sel_in;
   logic               oob_ff, oob_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_range_ff, rsp_range_in;

   logic                mem_we, mem_re;
   logic                out_free;
   logic [BASE_W-1:0]   nbr_off, nbr_addr;
   logic [DATA_W-1:0]   rd_byte;
   logic [ACC_W-1:0]    prod;
   logic [WEIGHT_W-1:0] fx16, fy16, a3w;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign nbr_off  = (nbr_ff[1] ? BASE_W'(cfg.stride) : '0)
                   + (nbr_ff[0] ? BASE_W'(cfg.chans) : '0);
   assign nbr_addr = base_ff + nbr_off;
   assign rd_byte  = oob_ff ? '0 : rdata_ff;
   assign prod     = ACC_W'(w_ff[rd_sel_ff]) * ACC_W'(rd_byte);

   assign fx16 = WEIGHT_W'({pop_cmd.fx, {(WEIGHT_BITS-FRAC_BITS){1'b0}}});
   assign fy16 = WEIGHT_W'({pop_cmd.fy, {(WEIGHT_BITS-FRAC_BITS){1'b0}}});
   assign a3w  = WEIGHT_W'(pop_cmd.a3);

   always_comb begin
      state_in     = state_ff;
      nbr_in       = nbr_ff;
      base_in      = base_ff;
      w_in         = w_ff;
      acc_in       = rd_valid_ff ? acc_ff + prod : acc_ff;
      rd_valid_in  = 1'b0;
      rd_sel_in    = rd_sel_ff;
      oob_in       = oob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in = rsp_value_ff;
      rsp_range_in = rsp_range_ff;
      pop_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               if (pop_cmd.is_write) begin
                  pop_ready = 1'b1;
                  mem_we    = 1'b1;
               end else if (!pop_cmd.in_range) begin
                  if (out_free) begin
                     pop_ready    = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_range_in = 1'b0;
                  end
               end else begin
                  pop_ready = 1'b1;
                  base_in   = pop_cmd.base;
                  w_in[0]   = WEIGHT_W'(WEIGHT_ONE) - fx16 - fy16 + a3w;
                  w_in[1]   = fx16 - a3w;
                  w_in[2]   = fy16 - a3w;
                  w_in[3]   = a3w;
                  acc_in    = '0;
                  nbr_in    = '0;
                  state_in  = BK_FETCH;
               end
            end
         end
         BK_FETCH: begin
            mem_re      = 1'b1;
            rd_valid_in = 1'b1;
            rd_sel_in   = nbr_ff;
            oob_in      = (nbr_addr >= BASE_W'(STORE_DEPTH));
            nbr_in      = nbr_ff + NBR_W'(1);
            if (nbr_ff == NBR_W'(NBR_COUNT - 1)) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            state_in = BK_PUSH;
         end
         BK_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = acc_ff[OUT_SHIFT +: VALUE_W];
               rsp_range_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pop_cmd.waddr] <= pop_cmd.wdata;
      end else if (mem_re) begin
         rdata_ff <= mem[nbr_addr[STORE_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nbr_ff       <= nbr_in;
      base_ff      <= base_in;
      w_ff         <= w_in;
      acc_ff       <= acc_in;
      rd_sel_ff    <= rd_sel_in;
      oob_ff       <= oob_in;
      rsp_value_ff <= rsp_value_in;
      rsp_range_ff <= rsp_range_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sample_value = rsp_value_ff;
   assign rsp_if.in_range     = rsp_range_ff;

endmodule
